[rtl/ert_pkg.sv]
// shared types and constants of the echo round-trip tracker
`timescale 1ns / 1ps
`default_nettype none

package ert_pkg;

    // slot table and send bookkeeping
    localparam int SLOTS      = 128;
    localparam int SEND_LIMIT = 128;
    localparam int MIN_START  = 1024;

    // time units
    localparam int USEC_PER_SEC = 1000000;
    localparam int USEC_PER_MS  = 1000;
    localparam int MS_PER_SEC   = 1000;

    // reciprocal of USEC_PER_MS, exact for magnitudes below 2**21
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_MS    = ((2 ** RECIP_SHIFT) + USEC_PER_MS - 1) / USEC_PER_MS;

    typedef enum logic
    {
        OP_SEND  = 1'b0,
        OP_REPLY = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_SENT      = 3'd0,
        ST_NO_SLOT   = 3'd1,
        ST_RTT       = 3'd2,
        ST_FOREIGN   = 3'd3,
        ST_UNMATCHED = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE    = 3'd0,
        S_SCAN    = 3'd1,
        S_CALC    = 3'd2,
        S_STATS   = 3'd3,
        S_PUBLISH = 3'd4
    } state_t;

    // lookup travelling down the row of slot cells
    typedef struct packed
    {
        logic        valid;
        op_t         op;
        logic        hit;
        logic [15:0] seq;
        logic [31:0] sec;
        logic [19:0] usec;
    } query_t;

endpackage

`default_nettype wire

[rtl/ert_if.sv]
// valid/ready channel interfaces for events and results
`timescale 1ns / 1ps
`default_nettype none

interface ert_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] reply_id;
    logic [15:0] reply_seq;
    logic [31:0] now_sec;
    logic [19:0] now_usec;

    modport source
    (
        output valid, action, reply_id, reply_seq, now_sec, now_usec,
        input  ready
    );
    modport sink
    (
        input  valid, action, reply_id, reply_seq, now_sec, now_usec,
        output ready
    );
endinterface

interface ert_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  assigned_seq;
    logic [31:0] rtt_ms;
    logic [7:0]  sent_total;
    logic [15:0] received_total;
    logic [31:0] rtt_low;
    logic [31:0] rtt_high;
    logic [47:0] rtt_total;
    logic        limit_hit;

    modport source
    (
        output valid, status, assigned_seq, rtt_ms, sent_total, received_total,
               rtt_low, rtt_high, rtt_total, limit_hit,
        input  ready
    );
    modport sink
    (
        input  valid, status, assigned_seq, rtt_ms, sent_total, received_total,
               rtt_low, rtt_high, rtt_total, limit_hit,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ert_cell.sv]
// one slot of the outstanding-request table, passes the lookup to its neighbor
`timescale 1ns / 1ps
`default_nettype none

module ert_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ert_pkg::query_t q_in,
    output ert_pkg::query_t      q_out
);

    logic            busy_reg;
    logic            busy_next;
    logic [15:0]     seq_reg;
    logic [15:0]     seq_next;
    logic [31:0]     sec_reg;
    logic [19:0]     usec_reg;
    logic            wr_en;
    ert_pkg::query_t q_reg;
    ert_pkg::query_t q_next;

    // claim a free slot on send, release the matching slot on reply
    always_comb
    begin
        q_next    = q_in;
        busy_next = busy_reg;
        seq_next  = seq_reg;
        wr_en     = 1'b0;
        if (q_in.valid && !q_in.hit)
        begin
            case (q_in.op)
                ert_pkg::OP_SEND:
                begin
                    if (!busy_reg)
                    begin
                        busy_next  = 1'b1;
                        seq_next   = q_in.seq;
                        wr_en      = 1'b1;
                        q_next.hit = 1'b1;
                    end
                end
                ert_pkg::OP_REPLY:
                begin
                    if (busy_reg && (seq_reg == q_in.seq))
                    begin
                        busy_next   = 1'b0;
                        q_next.hit  = 1'b1;
                        q_next.sec  = sec_reg;
                        q_next.usec = usec_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot state and the lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seq_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            seq_reg  <= seq_next;
            q_reg    <= q_next;
        end
    end

    // send time, only read back from a busy slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sec_reg  <= q_in.sec;
            usec_reg <= q_in.usec;
        end
    end

    assign q_out = q_reg;

endmodule

`default_nettype wire

[rtl/ert_chain.sv]
// row of slot cells, a lookup advances one cell per clock
`timescale 1ns / 1ps
`default_nettype none

module ert_chain
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ert_pkg::query_t q_in,
    output ert_pkg::query_t      q_out
);

    ert_pkg::query_t link [ert_pkg::SLOTS + 1];

    assign link[0] = q_in;

    // first cell in the row has priority, as the lookup meets it first
    for (genvar i = 0; i < ert_pkg::SLOTS; i++)
    begin : g_cell
        ert_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .q_in  (link[i]),
            .q_out (link[i + 1])
        );
    end

    assign q_out = link[ert_pkg::SLOTS];

endmodule

`default_nettype wire

[rtl/ert_rtt.sv]
// three-stage interval unit: borrow, scale to milliseconds, clamp
`timescale 1ns / 1ps
`default_nettype none

module ert_rtt
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] t0_sec,
    input  wire logic [19:0] t0_usec,
    input  wire logic [31:0] t1_sec,
    input  wire logic [19:0] t1_usec,
    output logic             done,
    output logic [31:0]      rtt_ms
);

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic signed [20:0] dusec_raw;
    logic               borrow;
    logic signed [21:0] dusec_adj;
    logic signed [33:0] dsec_adj;
    logic signed [33:0] s1_dsec_reg;
    logic signed [21:0] s1_dusec_reg;
    logic [21:0]        dusec_neg;
    logic               neg;
    logic [20:0]        mag;
    logic [41:0]        qprod;
    logic signed [43:0] prod;
    logic signed [43:0] s2_prod_reg;
    logic [10:0]        s2_qmag_reg;
    logic               s2_neg_reg;
    logic signed [11:0] qs;
    logic signed [44:0] ms;
    logic [31:0]        ms_sat;
    logic [31:0]        rtt_reg;

    // stage 1: differences with microsecond borrow
    always_comb
    begin
        dusec_raw = $signed({1'b0, t1_usec}) - $signed({1'b0, t0_usec});
        borrow    = dusec_raw[20];
        dusec_adj = 22'(dusec_raw)
                    + (borrow ? 22'(ert_pkg::USEC_PER_SEC) : 22'sd0);
        dsec_adj  = $signed({2'b00, t1_sec}) - $signed({2'b00, t0_sec})
                    - $signed({33'd0, borrow});
    end

    // stage 2: seconds to ms, microseconds divided by 1000 toward zero
    always_comb
    begin
        dusec_neg = -s1_dusec_reg;
        neg       = s1_dusec_reg[21];
        mag       = neg ? dusec_neg[20:0] : s1_dusec_reg[20:0];
        qprod     = 42'(mag) * 42'(ert_pkg::RECIP_MS);
        prod      = 44'(s1_dsec_reg) * 44'(ert_pkg::MS_PER_SEC);
    end

    // stage 3: sum and clamp to the 32-bit range
    always_comb
    begin
        qs = s2_neg_reg ? -$signed({1'b0, s2_qmag_reg}) : $signed({1'b0, s2_qmag_reg});
        ms = 45'(s2_prod_reg) + 45'(qs);
        if (ms[44])
        begin
            ms_sat = '0;
        end
        else if (ms[43:32] != '0)
        begin
            ms_sat = '1;
        end
        else
        begin
            ms_sat = ms[31:0];
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        s1_dsec_reg  <= dsec_adj;
        s1_dusec_reg <= dusec_adj;
        s2_prod_reg  <= prod;
        s2_qmag_reg  <= 11'(qprod >> ert_pkg::RECIP_SHIFT);
        s2_neg_reg   <= neg;
        rtt_reg      <= ms_sat;
    end

    assign done   = v3_reg;
    assign rtt_ms = rtt_reg;

endmodule

`default_nettype wire

[rtl/echo_rtt_tracker_top.sv]
// top level of the echo round-trip tracker
`timescale 1ns / 1ps
`default_nettype none

// Tracks up to 128 outstanding echo requests and measures round-trip times.
// One event is handled at a time. A send, or a reply carrying our id, walks
// the row of 128 slot cells one cell per clock; a reply that finds its slot
// then passes the three-stage interval unit and the statistics update. A send
// after the limit or a reply with a foreign id skips the row. The result sits
// in an output register, so the next event is taken while it waits for its
// transfer. The user must write own_id through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this.

module echo_rtt_tracker_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    ert_in_if.sink           in_ch,
    ert_out_if.source        out_ch
);

    ert_pkg::state_t  state_reg;
    ert_pkg::state_t  state_next;
    logic [15:0]      own_id_reg;
    logic [7:0]       sent_reg;
    logic [7:0]       sent_plus;
    logic             stop_reg;
    logic [15:0]      recv_reg;
    logic [47:0]      sum_reg;
    logic [48:0]      sum_wide;
    logic [31:0]      min_reg;
    logic [31:0]      max_reg;
    ert_pkg::op_t     act_reg;
    logic [31:0]      now_sec_reg;
    logic [19:0]      now_usec_reg;
    ert_pkg::status_t status_reg;
    logic [7:0]       aseq_reg;
    logic [31:0]      rtt_res_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             is_send;
    logic             need_scan;
    logic             rtt_start;
    logic             rtt_done;
    logic [31:0]      rtt_ms;
    logic             out_load;
    logic             in_ready;
    ert_pkg::query_t  q_in;
    ert_pkg::query_t  chain_out;

    // event decode
    always_comb
    begin
        is_send   = (ert_pkg::op_t'(in_ch.action) == ert_pkg::OP_SEND);
        sent_plus = sent_reg + 8'd1;
        need_scan = is_send ? !stop_reg : (in_ch.reply_id == own_id_reg);
        accept    = in_ready && in_ch.valid;
    end

    // lookup launched into the slot row
    always_comb
    begin
        q_in.valid = accept && need_scan;
        q_in.op    = ert_pkg::op_t'(in_ch.action);
        q_in.hit   = 1'b0;
        q_in.seq   = is_send ? 16'(sent_plus) : in_ch.reply_seq;
        q_in.sec   = in_ch.now_sec;
        q_in.usec  = in_ch.now_usec;
    end

    ert_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .q_in  (q_in),
        .q_out (chain_out)
    );

    ert_rtt u_rtt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rtt_start),
        .t0_sec  (chain_out.sec),
        .t0_usec (chain_out.usec),
        .t1_sec  (now_sec_reg),
        .t1_usec (now_usec_reg),
        .done    (rtt_done),
        .rtt_ms  (rtt_ms)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ert_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = need_scan ? ert_pkg::S_SCAN : ert_pkg::S_PUBLISH;
                end
            end
            ert_pkg::S_SCAN:
            begin
                if (chain_out.valid)
                begin
                    state_next = (chain_out.hit && (act_reg == ert_pkg::OP_REPLY))
                                 ? ert_pkg::S_CALC : ert_pkg::S_PUBLISH;
                end
            end
            ert_pkg::S_CALC:
            begin
                if (rtt_done)
                begin
                    state_next = ert_pkg::S_STATS;
                end
            end
            ert_pkg::S_STATS:
            begin
                state_next = ert_pkg::S_PUBLISH;
            end
            ert_pkg::S_PUBLISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ert_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ert_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        rtt_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ert_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            ert_pkg::S_SCAN:
            begin
                rtt_start = chain_out.valid && chain_out.hit
                            && (act_reg == ert_pkg::OP_REPLY);
            end
            ert_pkg::S_PUBLISH:
            begin
                out_load = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
            end
        endcase
    end

    // saturating sum of round trips
    assign sum_wide = {1'b0, sum_reg} + 49'(rtt_res_reg);

    // control state, counters and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ert_pkg::S_IDLE;
            own_id_reg    <= '0;
            sent_reg      <= '0;
            stop_reg      <= 1'b0;
            recv_reg      <= '0;
            sum_reg       <= '0;
            min_reg       <= 32'(ert_pkg::MIN_START);
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                own_id_reg <= cfg_wdata;
            end
            if (accept && is_send && !stop_reg)
            begin
                sent_reg <= sent_plus;
                if (sent_plus == 8'(ert_pkg::SEND_LIMIT))
                begin
                    stop_reg <= 1'b1;
                end
            end
            if (state_reg == ert_pkg::S_STATS)
            begin
                if (recv_reg != '1)
                begin
                    recv_reg <= recv_reg + 16'd1;
                end
                sum_reg <= sum_wide[48] ? '1 : sum_wide[47:0];
                if (rtt_res_reg > max_reg)
                begin
                    max_reg <= rtt_res_reg;
                end
                if (rtt_res_reg < min_reg)
                begin
                    min_reg <= rtt_res_reg;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // event payload and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= ert_pkg::op_t'(in_ch.action);
            now_sec_reg  <= in_ch.now_sec;
            now_usec_reg <= in_ch.now_usec;
            status_reg   <= is_send ? ert_pkg::ST_NO_SLOT : ert_pkg::ST_FOREIGN;
            aseq_reg     <= (is_send && !stop_reg) ? sent_plus : 8'd0;
            rtt_res_reg  <= '0;
        end
        if ((state_reg == ert_pkg::S_SCAN) && chain_out.valid)
        begin
            if (act_reg == ert_pkg::OP_SEND)
            begin
                status_reg <= chain_out.hit ? ert_pkg::ST_SENT : ert_pkg::ST_NO_SLOT;
            end
            else
            begin
                status_reg <= chain_out.hit ? ert_pkg::ST_RTT : ert_pkg::ST_UNMATCHED;
            end
        end
        if (rtt_done)
        begin
            rtt_res_reg <= rtt_ms;
        end
        if (out_load)
        begin
            out_ch.status         <= status_reg;
            out_ch.assigned_seq   <= aseq_reg;
            out_ch.rtt_ms         <= rtt_res_reg;
            out_ch.sent_total     <= sent_reg;
            out_ch.received_total <= recv_reg;
            out_ch.rtt_low        <= min_reg;
            out_ch.rtt_high       <= max_reg;
            out_ch.rtt_total      <= sum_reg;
            out_ch.limit_hit      <= stop_reg;
        end
    end

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid_reg;

    // a lookup leaves the slot row only while the sequencer waits for it
    a_chain_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == ert_pkg::S_SCAN))
        else $error("lookup left the slot row outside the scan");

    // the interval unit finishes only while the sequencer waits for it
    a_rtt_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        rtt_done |-> (state_reg == ert_pkg::S_CALC))
        else $error("interval result outside the calc state");

    // the stop flag comes only with the send limit reached
    a_stop_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> (sent_reg == 8'(ert_pkg::SEND_LIMIT)))
        else $error("stop flag without send limit");

    // once a round trip is measured, the low bound cannot pass the high bound
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (recv_reg != '0) |-> (min_reg <= max_reg))
        else $error("round-trip low bound above high bound");

    // a result loaded into the output register is offered in the next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result lost at output register");

endmodule

`default_nettype wire
